// ===== hdl/tmn_pkg.sv =====
package tmn_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned STEP_BITS_DEF   = 20;
  localparam int unsigned MAX_RATCHET_DEF = 8;

  // Fixed field widths.
  localparam int unsigned STEP_IN_W = 20;
  localparam int unsigned TICK_W    = 28;
  localparam int unsigned RC_W      = 4;
  localparam int unsigned CFG_W     = 9;

  // Configuration register indexes.
  localparam logic CFG_SWING  = 1'b0;
  localparam logic CFG_TRACKS = 1'b1;

  // One 16th note in 1/256-tick units, and its share per hit for 1..16 hits.
  localparam logic [15:0] STEP_FIX = 16'd61440;
  localparam logic [15:0] SPACING_LUT [17] = '{
    16'd61440, 16'd61440, 16'd30720, 16'd20480, 16'd15360, 16'd12288,
    16'd10240, 16'd8777,  16'd7680,  16'd6826,  16'd6144,  16'd5585,
    16'd5120,  16'd4726,  16'd4388,  16'd4096,  16'd3840
  };

  // Quotient bits of the velocity divide; the quotient never exceeds 127.
  localparam int unsigned DIV_STEPS = 7;

  localparam int unsigned UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_BASE,
    OP_TIMING,
    OP_NUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    J_WAIT_IN,
    J_NEXT,
    J_JUMP,
    J_DROP,
    J_SINGLE,
    J_DIV_LOOP,
    J_EMIT
  } jmp_e;

  // Program addresses.
  localparam upc_t UA_IDLE     = 3'd0;
  localparam upc_t UA_BASE     = 3'd1;
  localparam upc_t UA_TIMING   = 3'd2;
  localparam upc_t UA_NUM      = 3'd3;
  localparam upc_t UA_DIV_INIT = 3'd4;
  localparam upc_t UA_DIV      = 3'd5;
  localparam upc_t UA_EMIT     = 3'd6;

  typedef struct packed {
    op_e  op;
    jmp_e jmp;
    upc_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_blocked;
    logic drop;
    logic single;
    logic div_last;
    logic last_hit;
  } seq_stat_t;

  typedef struct packed {
    op_e  op;
    logic fire;
    logic idle;
  } seq_ctl_t;

  // The control store.
  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    case (addr)
      UA_IDLE:     w = '{op: OP_LATCH,    jmp: J_WAIT_IN,  target: UA_IDLE};
      UA_BASE:     w = '{op: OP_BASE,     jmp: J_DROP,     target: UA_IDLE};
      UA_TIMING:   w = '{op: OP_TIMING,   jmp: J_NEXT,     target: UA_IDLE};
      UA_NUM:      w = '{op: OP_NUM,      jmp: J_SINGLE,   target: UA_EMIT};
      UA_DIV_INIT: w = '{op: OP_DIV_INIT, jmp: J_NEXT,     target: UA_IDLE};
      UA_DIV:      w = '{op: OP_DIV_STEP, jmp: J_DIV_LOOP, target: UA_DIV};
      UA_EMIT:     w = '{op: OP_EMIT,     jmp: J_EMIT,     target: UA_NUM};
      default:     w = '{op: OP_NOP,      jmp: J_JUMP,     target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/trig_to_midi_notes_unit.sv =====
// An accepted word is latched; base and timing steps prepare its first hit, or a drop ends it.
// Each hit takes the numerator step, plus with R > 1 hits the restoring divide of the velocity
// ramp, before its emit. A new word is taken only after the last hit has been emitted.
// Reset is asynchronous and active low: swing_amount 0, track_count 16, no word pending.
// A finished note waits in the output register while the next hit is computed.
module trig_to_midi_notes_unit import tmn_pkg::*; #(
  parameter int unsigned STEP_BITS   = STEP_BITS_DEF,
  parameter int unsigned MAX_RATCHET = MAX_RATCHET_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [STEP_IN_W-1:0] step_index_i,
  input  logic [7:0]           track_number_i,
  input  logic signed [6:0]    micro_shift_i,
  input  logic signed [7:0]    pitch_offset_i,
  input  logic [9:0]           gate_sixteenths_i,
  input  logic [RC_W-1:0]      ratchet_count_i,
  input  logic signed [8:0]    fade_amount_i,
  input  logic [6:0]           hit_velocity_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [4:0]           midi_channel_o,
  output logic [6:0]           note_number_o,
  output logic [6:0]           note_velocity_o,
  output logic [TICK_W-1:0]    on_tick_o,
  output logic [TICK_W-1:0]    off_tick_o,
  output logic                 last_hit_o
);

  // Hit counts run 1..MAX_RATCHET. Times are unsigned in 1/256-tick units and
  // wide enough that the 28 tick bits can always be cut out of them.
  localparam int unsigned RT_W   = $clog2(MAX_RATCHET + 1);
  localparam int unsigned TIME_W = (STEP_BITS + 17 > 36) ? STEP_BITS + 17 : 36;

  seq_stat_t stat;
  seq_ctl_t  ctl;

  // Configuration registers.
  logic [8:0] swing_q;
  logic [6:0] tracks_q;

  // Trig fields, captured and partly prepared when the word is taken.
  logic [STEP_BITS-1:0] step_q;
  logic                 drop_q;
  logic [4:0]           chan_q;
  logic [6:0]           note_q;
  logic [5:0]           micro_q;
  logic [21:0]          gate_q;
  logic [RT_W-1:0]      rt_q;
  logic                 fneg_q;
  logic [7:0]           fmag_q;
  logic [6:0]           vel_q;

  // Working registers of the hit loop.
  logic [TIME_W-1:0]    on_q;
  logic [15:0]          spacing_q;
  logic [21:0]          lenoff_q;
  logic [RT_W-1:0]      k_q;
  logic [10:0]          num_q;
  logic [18:0]          rem_q;
  logic [17:0]          dsh_q;
  logic [6:0]           quo_q;
  logic [2:0]           cnt_q;

  // Output register.
  logic                 out_valid_q;
  logic [4:0]           chan_out_q;
  logic [6:0]           note_out_q;
  logic [6:0]           vel_out_q;
  logic [TICK_W-1:0]    on_tick_q;
  logic [TICK_W-1:0]    off_tick_q;
  logic                 last_out_q;

  // Capture-time preparation of the trig fields.
  logic signed [8:0]    note_sum;
  logic [6:0]           note_clamped;
  logic [21:0]          gate_fix;
  logic [RT_W-1:0]      rt_clamped;
  logic [9:0]           fade_ext;
  logic [9:0]           fade_abs;
  logic [7:0]           fade_mag;

  assign note_sum = 9'sd60 + 9'(pitch_offset_i);

  always_comb begin
    if (note_sum[8]) begin
      note_clamped = 7'd0;
    end else if (note_sum[7]) begin
      note_clamped = 7'd127;
    end else begin
      note_clamped = note_sum[6:0];
    end
  end

  // A zero gate means one full 16th; otherwise 15 ticks per unit.
  assign gate_fix = (gate_sixteenths_i == 10'd0) ? 22'(STEP_FIX)
                  : ({gate_sixteenths_i, 12'b0} - {4'b0, gate_sixteenths_i, 8'b0});

  assign rt_clamped = (ratchet_count_i == '0) ? RT_W'(1)
                    : ((32'(ratchet_count_i) > MAX_RATCHET) ? RT_W'(MAX_RATCHET)
                                                             : RT_W'(ratchet_count_i));

  assign fade_ext = {fade_amount_i[8], fade_amount_i};
  assign fade_abs = fade_amount_i[8] ? (~fade_ext + 10'd1) : fade_ext;
  assign fade_mag = (fade_abs > 10'd128) ? 8'd128 : fade_abs[7:0];

  // Loop arithmetic. The ramp runs over D = R - 1 intervals and never
  // exceeds 14 of them, so D and k fit the ratchet field width.
  logic [RC_W-1:0]      d_w;
  logic [RC_W-1:0]      k_w;
  logic [RC_W-1:0]      mfac;
  logic [11:0]          fade_prod;
  logic [17:0]          vel_prod;
  logic [TIME_W-1:0]    step_fix;
  logic [15:0]          swing_fix;
  logic [16:0]          micro_fix;
  logic [21:0]          len_min;
  logic [21:0]          len_sel;
  logic                 div_ge;
  logic [TIME_W:0]      on_round;
  logic [TIME_W:0]      off_round;
  logic                 single;
  logic                 last_hit;

  assign d_w  = RC_W'(rt_q - RT_W'(1));
  assign k_w  = RC_W'(k_q);
  assign mfac = fneg_q ? k_w : (d_w - k_w);

  // A swell starts low and rises to the base velocity; a fade starts there
  // and falls. Either way the numerator stays within 0..128*D.
  assign fade_prod = fmag_q * mfac;
  assign vel_prod  = vel_q * num_q;

  assign step_fix  = TIME_W'({step_q, 16'b0}) - TIME_W'({step_q, 12'b0});
  assign swing_fix = {swing_q, 7'b0} - {4'b0, swing_q, 3'b0};
  assign micro_fix = {1'b0, micro_q, 10'b0} + {3'b0, micro_q, 8'b0};

  assign single   = (rt_q == RT_W'(1));
  assign last_hit = (k_q == rt_q - RT_W'(1));

  assign len_min = (gate_q < 22'(spacing_q)) ? gate_q : 22'(spacing_q);
  assign len_sel = single ? gate_q : len_min;

  assign div_ge = (rem_q >= {1'b0, dsh_q});

  // Round half up to whole ticks; the tick count wraps at 28 bits.
  assign on_round  = {1'b0, on_q} + (TIME_W + 1)'(128);
  assign off_round = {1'b0, on_q} + (TIME_W + 1)'(lenoff_q) + (TIME_W + 1)'(128);

  // Status toward the sequencer.
  always_comb begin
    stat.in_valid    = in_valid_i;
    stat.out_blocked = out_valid_q && !out_ready_i;
    stat.drop        = drop_q;
    stat.single      = single;
    stat.div_last    = (cnt_q == 3'(DIV_STEPS - 1));
    stat.last_hit    = last_hit;
  end

  tmn_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  assign in_ready_o = ctl.idle;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_q  <= 9'd0;
      tracks_q <= 7'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SWING:  swing_q  <= cfg_data_i;
        CFG_TRACKS: tracks_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Datapath. Each program step fires one operation.
  always_ff @(posedge clk_i) begin
    if (ctl.fire) begin
      case (ctl.op)
        OP_LATCH: begin
          step_q  <= STEP_BITS'(step_index_i);
          drop_q  <= (track_number_i >= {1'b0, tracks_q});
          chan_q  <= {1'b0, track_number_i[3:0]} + 5'd1;
          note_q  <= note_clamped;
          // Only a late micro shift moves the note.
          micro_q <= micro_shift_i[6] ? 6'd0 : micro_shift_i[5:0];
          gate_q  <= gate_fix;
          rt_q    <= rt_clamped;
          fneg_q  <= fade_amount_i[8];
          fmag_q  <= fade_mag;
          vel_q   <= hit_velocity_i;
        end
        OP_BASE: begin
          // Odd steps are pulled earlier by swing. The largest swing still
          // leaves an odd step above zero, so the start never goes negative.
          on_q      <= step_q[0] ? (step_fix - TIME_W'(swing_fix)) : step_fix;
          spacing_q <= SPACING_LUT[5'(rt_q)];
          k_q       <= '0;
        end
        OP_TIMING: begin
          on_q     <= on_q + TIME_W'(micro_fix);
          lenoff_q <= (len_sel < 22'd256) ? 22'd256 : len_sel;
        end
        OP_NUM: begin
          num_q <= {d_w, 7'b0} - 11'(fade_prod);
          quo_q <= vel_q;
        end
        OP_DIV_INIT: begin
          // Velocity is (2*v*num + 128*D) / (256*D), rounded half up.
          rem_q <= {vel_prod, 1'b0} + 19'({d_w, 7'b0});
          dsh_q <= {d_w, 14'b0};
          quo_q <= 7'd0;
          cnt_q <= 3'd0;
        end
        OP_DIV_STEP: begin
          if (div_ge) rem_q <= rem_q - {1'b0, dsh_q};
          quo_q <= {quo_q[5:0], div_ge};
          dsh_q <= {1'b0, dsh_q[17:1]};
          cnt_q <= cnt_q + 3'd1;
        end
        OP_EMIT: begin
          chan_out_q <= chan_q;
          note_out_q <= note_q;
          vel_out_q  <= (quo_q == 7'd0) ? 7'd1 : quo_q;
          on_tick_q  <= on_round[TICK_W+7:8];
          off_tick_q <= off_round[TICK_W+7:8];
          last_out_q <= last_hit;
          on_q       <= on_q + TIME_W'(spacing_q);
          k_q        <= k_q + RT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // The output word stays until it is taken; a new one may load in the same
  // cycle the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.fire && ctl.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign midi_channel_o  = chan_out_q;
  assign note_number_o   = note_out_q;
  assign note_velocity_o = vel_out_q;
  assign on_tick_o       = on_tick_q;
  assign off_tick_o      = off_tick_q;
  assign last_hit_o      = last_out_q;

endmodule

// ===== hdl/tmn_seq.sv =====
module tmn_seq import tmn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output seq_ctl_t  ctl_o
);

  upc_t   upc_q, upc_d;
  uword_t uw;

  assign uw = ucode(upc_q);

  always_comb begin : next_upc
    upc_d = upc_q + upc_t'(1);
    case (uw.jmp)
      J_WAIT_IN: begin
        if (!stat_i.in_valid) upc_d = upc_q;
      end
      J_NEXT: begin
        upc_d = upc_q + upc_t'(1);
      end
      J_JUMP: begin
        upc_d = uw.target;
      end
      J_DROP: begin
        if (stat_i.drop) upc_d = uw.target;
      end
      J_SINGLE: begin
        if (stat_i.single) upc_d = uw.target;
      end
      J_DIV_LOOP: begin
        if (!stat_i.div_last) upc_d = uw.target;
      end
      J_EMIT: begin
        if (stat_i.out_blocked) begin
          upc_d = upc_q;
        end else if (stat_i.last_hit) begin
          upc_d = UA_IDLE;
        end else begin
          upc_d = uw.target;
        end
      end
      default: begin
        upc_d = UA_IDLE;
      end
    endcase
  end

  always_comb begin : ctl_out
    ctl_o.op   = uw.op;
    ctl_o.idle = (upc_q == UA_IDLE);
    case (uw.jmp)
      J_WAIT_IN: ctl_o.fire = stat_i.in_valid;
      J_EMIT:    ctl_o.fire = !stat_i.out_blocked;
      default:   ctl_o.fire = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== dv/trig_to_midi_notes_unit_test.sv =====
module trig_to_midi_notes_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmn_pkg::*;

  // Cycles to let pass once nothing is expected. A dropped trig gives no note,
  // so the block may still be busy after the last note left it.
  localparam int SETTLE_CYCLES = 24;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int RX_HOLD_CYCLES = 400;

  // Fixed-point constants of the timing math, in 1/256-tick units.
  localparam longint FIX_PER_STEP = 61440;
  localparam longint FIX_PER_TICK = 256;
  localparam longint TICK_MASK = 64'h0FFF_FFFF;

  // One trig word as it goes into the block.
  typedef struct {
    logic [STEP_IN_W-1:0] step;
    logic [7:0]           track;
    logic signed [6:0]    micro;
    logic signed [7:0]    pitch;
    logic [9:0]           gate;
    logic [RC_W-1:0]      ratchet;
    logic signed [8:0]    fade;
    logic [6:0]           vel;
  } trig_t;

  // One note word as it leaves the block.
  typedef struct {
    logic [4:0]        channel;
    logic [6:0]        note_num;
    logic [6:0]        velocity;
    logic [TICK_W-1:0] on_tick;
    logic [TICK_W-1:0] off_tick;
    logic              last_hit;
  } note_t;

  // Keeps a copy of the two registers, works out the notes of each accepted
  // trig and matches the notes that come out against them in order.
  class note_tracker;
    logic [8:0] swing;
    logic [6:0] tracks;
    note_t      notes_due[$];
    int         errors;

    function new();
      swing  = '0;
      tracks = 7'd16;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_SWING) begin
        swing = data;
      end else begin
        tracks = data[6:0];
      end
    endfunction

    function int pending();
      return notes_due.size();
    endfunction

    static function longint to_tick(longint fx);
      return ((fx + FIX_PER_TICK / 2) >> 8) & TICK_MASK;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Queues the notes of one accepted trig and returns how many there are.
    function int book_trig(trig_t t);
      longint step, micro, pitch, gsix, fade, vel;
      longint base, gate, spacing, hits, span, num, start, len, v;
      note_t  n;
      if (t.track >= tracks) return 0;
      step  = t.step;
      micro = t.micro;
      pitch = t.pitch;
      gsix  = t.gate;
      fade  = clip(longint'(t.fade), -128, 128);
      vel   = t.vel;
      hits  = clip(longint'(t.ratchet), 1, MAX_RATCHET_DEF);

      // Odd steps are pulled earlier by swing; only a late micro shift counts.
      base = step * FIX_PER_STEP;
      if (t.step[0]) base -= longint'(swing) * 120;
      if (micro > 0) base += micro * 5 * FIX_PER_TICK;
      if (base < 0) base = 0;

      gate    = gsix > 0 ? gsix * 15 * FIX_PER_TICK : FIX_PER_STEP;
      spacing = FIX_PER_STEP / hits;
      span    = hits - 1;

      for (longint k = 0; k < hits; k++) begin
        if (hits == 1) begin
          start = base;
          len   = gate;
          v     = vel;
        end else begin
          // Linear ramp: a swell climbs to full velocity, a fade falls from it.
          num   = fade >= 0 ? 128 * span - fade * (span - k) : 128 * span + fade * k;
          start = base + k * spacing;
          len   = gate < spacing ? gate : spacing;
          v     = (2 * vel * num + 128 * span) / (256 * span);
        end
        n.channel  = 5'(t.track[3:0]) + 5'd1;
        n.note_num = 7'(clip(60 + pitch, 0, 127));
        n.velocity = 7'(clip(v, 1, 127));
        n.on_tick  = TICK_W'(to_tick(start));
        n.off_tick = TICK_W'(to_tick(start + (len > FIX_PER_TICK ? len : FIX_PER_TICK)));
        n.last_hit = (k == hits - 1);
        notes_due.push_back(n);
      end
      return int'(hits);
    endfunction

    function void compare(string field, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void match_note(note_t got);
      note_t want;
      if (notes_due.size() == 0) begin
        $display("%0t ns: unexpected note, expected none, actual on_tick %0d note %0d",
                 $time, got.on_tick, got.note_num);
        errors++;
        return;
      end
      want = notes_due.pop_front();
      compare("midi_channel",  TICK_W'(want.channel),  TICK_W'(got.channel));
      compare("note_number",   TICK_W'(want.note_num), TICK_W'(got.note_num));
      compare("note_velocity", TICK_W'(want.velocity), TICK_W'(got.velocity));
      compare("on_tick",       want.on_tick,           got.on_tick);
      compare("off_tick",      want.off_tick,          got.off_tick);
      compare("last_hit",      TICK_W'(want.last_hit), TICK_W'(got.last_hit));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [STEP_IN_W-1:0] step_index_i;
  logic [7:0]           track_number_i;
  logic signed [6:0]    micro_shift_i;
  logic signed [7:0]    pitch_offset_i;
  logic [9:0]           gate_sixteenths_i;
  logic [RC_W-1:0]      ratchet_count_i;
  logic signed [8:0]    fade_amount_i;
  logic [6:0]           hit_velocity_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [4:0]           midi_channel_o;
  logic [6:0]           note_number_o;
  logic [6:0]           note_velocity_o;
  logic [TICK_W-1:0]    on_tick_o;
  logic [TICK_W-1:0]    off_tick_o;
  logic                 last_hit_o;

  note_tracker tracker;

  // When set, neither side inserts gaps, so the block runs back to back.
  bit quiet_run = 1'b0;
  // A nonzero value asks the receiver for one long hold-off before its next word.
  int rx_hold_cycles = 0;

  trig_to_midi_notes_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .step_index_i      (step_index_i),
    .track_number_i    (track_number_i),
    .micro_shift_i     (micro_shift_i),
    .pitch_offset_i    (pitch_offset_i),
    .gate_sixteenths_i (gate_sixteenths_i),
    .ratchet_count_i   (ratchet_count_i),
    .fade_amount_i     (fade_amount_i),
    .hit_velocity_i    (hit_velocity_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .midi_channel_o    (midi_channel_o),
    .note_number_o     (note_number_o),
    .note_velocity_o   (note_velocity_o),
    .on_tick_o         (on_tick_o),
    .off_tick_o        (off_tick_o),
    .last_hit_o        (last_hit_o)
  );

  // A 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both sides draw a fresh random wait for every word, unless the
  // current phase is meant to run without gaps.
  function automatic int draw_gap();
    return quiet_run ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic trig_t make_trig(int step, int track, int micro, int pitch,
                                      int gate, int rc, int fade, int vel);
    trig_t t;
    t.step    = STEP_IN_W'(step);
    t.track   = 8'(track);
    t.micro   = 7'(micro);
    t.pitch   = 8'(pitch);
    t.gate    = 10'(gate);
    t.ratchet = RC_W'(rc);
    t.fade    = 9'(fade);
    t.vel     = 7'(vel);
    return t;
  endfunction

  // Random trigs mostly land on live tracks so that most of them make notes;
  // the rest hit any lane, live or not. Half of the micro shifts and fades
  // stay in their nominal ranges, the other half use every code of the field.
  function automatic trig_t random_trig();
    trig_t t;
    int    lanes;
    int    pick;
    lanes  = tracker.tracks;
    t.step = ($urandom_range(0, 3) == 0) ? STEP_IN_W'($urandom_range(0, 31))
                                         : STEP_IN_W'($urandom);
    t.track = (lanes > 0 && $urandom_range(0, 4) != 0) ? 8'($urandom_range(0, lanes - 1))
                                                        : 8'($urandom);
    t.micro = ($urandom_range(0, 1) == 0) ? 7'(int'($urandom_range(0, 96)) - 48)
                                          : 7'($urandom);
    t.pitch = 8'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      t.gate = '0;
    end else if (pick < 4) begin
      t.gate = 10'($urandom_range(1, 20));
    end else begin
      t.gate = 10'($urandom);
    end
    t.ratchet = RC_W'($urandom);
    t.fade = ($urandom_range(0, 1) == 0) ? 9'(int'($urandom_range(0, 256)) - 128)
                                         : 9'($urandom);
    t.vel = 7'($urandom);
    return t;
  endfunction

  // Offers one trig word and returns once the block has taken it. Valid is
  // only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_trig(input trig_t t, output int hits);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    step_index_i      <= t.step;
    track_number_i    <= t.track;
    micro_shift_i     <= t.micro;
    pitch_offset_i    <= t.pitch;
    gate_sixteenths_i <= t.gate;
    ratchet_count_i   <= t.ratchet;
    fade_amount_i     <= t.fade;
    hit_velocity_i    <= t.vel;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    hits = tracker.book_trig(t);
  endtask

  // Waits at least one cycle, and then until every booked note has come out.
  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Brings the block to rest: no word offered, nothing owed, and enough extra
  // cycles for a trailing dropped trig to clear the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic set_config(logic [8:0] swing, logic [6:0] lanes);
    write_reg(CFG_SWING, swing);
    write_reg(CFG_TRACKS, {2'b00, lanes});
    cfg_we_i <= 1'b0;
  endtask

  // Sends random trigs until the target is met. Only trigs that make notes
  // count, unless count_all is set. With pause_after set, the sender stops
  // once that many have gone in and waits for the block to empty out.
  task automatic run_phase(int target, bit count_all, int pause_after);
    int done;
    int hits;
    done = 0;
    while (done < target) begin
      send_trig(random_trig(), hits);
      if (hits > 0 || count_all) begin
        done++;
        if (done == pause_after) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
      end
    end
  endtask

  // Receiver: takes note words, with a random gap before each one, and a single
  // long hold-off when the stimulus asks for it.
  initial begin : note_sink
    int    gap;
    note_t got;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_hold_cycles > 0 ? rx_hold_cycles : draw_gap();
      rx_hold_cycles = 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.channel  = midi_channel_o;
      got.note_num = note_number_o;
      got.velocity = note_velocity_o;
      got.on_tick  = on_tick_o;
      got.off_tick = off_tick_o;
      got.last_hit = last_hit_o;
      tracker.match_note(got);
    end
  end

  initial begin : trig_source
    trig_t directed[$];
    int    hits;
    tracker = new();

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= CFG_SWING;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    step_index_i      <= '0;
    track_number_i    <= '0;
    micro_shift_i     <= '0;
    pitch_offset_i    <= '0;
    gate_sixteenths_i <= '0;
    ratchet_count_i   <= '0;
    fade_amount_i     <= '0;
    hit_velocity_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed trigs run on the reset settings: no swing, sixteen tracks.
    // A plain single hit on step zero.
    directed.push_back(make_trig(0, 0, 0, 0, 0, 1, 0, 100));
    // Odd step, largest nominal micro shift, top pitch, ratchet of zero taken as one.
    directed.push_back(make_trig(1, 15, 48, 127, 1, 0, 0, 127));
    // Last step, widest micro code, lowest pitch, longest gate, zero velocity.
    directed.push_back(make_trig(1048575, 3, 63, -128, 1023, 1, 0, 0));
    // Tracks at and far above the track count are dropped.
    directed.push_back(make_trig(1048574, 16, 10, 0, 0, 4, 0, 100));
    directed.push_back(make_trig(5, 255, 0, 0, 0, 8, 0, 100));
    // Negative micro shift is ignored; the note lands on the top value; full swell.
    directed.push_back(make_trig(2, 7, -64, 67, 0, 2, 128, 127));
    // Note clamps to zero; full fade over eight hits.
    directed.push_back(make_trig(3, 8, -48, -61, 0, 8, -128, 1));
    // Ratchet above the maximum, fade beyond the positive limit.
    directed.push_back(make_trig(4, 9, 0, 10, 5, 15, 255, 64));
    // Fade beyond the negative limit.
    directed.push_back(make_trig(6, 10, 1, -10, 2, 8, -256, 127));
    // Gate shorter than the hit spacing, then equal to it.
    directed.push_back(make_trig(7, 11, 5, 0, 5, 3, 0, 90));
    directed.push_back(make_trig(8, 12, 0, 0, 4, 4, 64, 80));
    // Spacing that does not divide evenly, with the gentlest fade.
    directed.push_back(make_trig(9, 13, 2, 3, 1023, 7, -1, 127));
    // Zero velocity is raised to one.
    directed.push_back(make_trig(10, 14, 0, 0, 0, 5, 1, 0));
    directed.push_back(make_trig(11, 1, 30, 4, 1, 6, -100, 50));
    directed.push_back(make_trig(524289, 2, 63, 0, 0, 9, 127, 127));
    directed.push_back(make_trig(12, 15, 0, 0, 1, 2, -128, 127));
    foreach (directed[i]) send_trig(directed[i], hits);
    settle();

    // Full swing and 64 tracks. The receiver holds off for a long stretch at
    // the start, so the block backs up and holds its input off.
    set_config(9'd256, 7'd64);
    rx_hold_cycles = RX_HOLD_CYCLES;
    run_phase(100, 1'b0, 0);
    settle();

    // Widest swing code and a single track, with no gaps on either side.
    quiet_run = 1'b1;
    set_config(9'd511, 7'd1);
    run_phase(60, 1'b0, 0);
    settle();
    quiet_run = 1'b0;

    // No swing and the largest track count; halfway through, the sender waits
    // until every note owed has come out.
    set_config(9'd0, 7'd127);
    run_phase(100, 1'b0, 50);
    settle();

    // A track count of zero drops every trig.
    set_config(9'($urandom_range(0, 511)), 7'd0);
    run_phase(12, 1'b1, 0);
    settle();

    // Random settings for the rest of the run.
    set_config(9'($urandom_range(0, 511)), 7'($urandom_range(1, 127)));
    run_phase(140, 1'b0, 0);
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tmn_pkg.sv
hdl/tmn_seq.sv
hdl/trig_to_midi_notes_unit.sv
dv/trig_to_midi_notes_unit_test.sv
